>>> hdl/vtmf_pkg.sv
// Package for the fuel-rate unit: shared constants, polynomial coefficients and side-band type.
// Used by vtmf_exp2_frac and vt_micro_fuel_rate_unit; depends on nothing.
`default_nettype none

package vtmf_pkg;

    // Width of the polynomial accumulator, signed Q30
    localparam int P_W = 44;

    localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    // Sum limits in Q30: saturate at 6.0, zero below -20.0
    localparam logic signed [P_W-1:0] T_SAT_Q30  = 44'sd6442450944;
    localparam logic signed [P_W-1:0] T_ZERO_Q30 = -44'sd21474836480;

    localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;   // with >> 35

    typedef struct packed {
        logic [5:0] k;          // integer part of the biased exponent
        logic       sat_hi;     // sum too large
        logic       zero_lo;    // sum too small
    } vtmf_side_t;

    // round(num * 2^sh / 10^dexp), half away from zero, dividing by shift and subtract
    function automatic logic signed [P_W-1:0] dec_to_fixed(input int num, input int dexp,
                                                         input int sh);
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] r;
        logic        neg;
        den = 64'd1;
        for (int i = 0; i < dexp; i++) den = den * 64'd10;
        neg = (num < 0);
        mag = neg ? 64'(-num) : 64'(num);
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], mag[i]};
            q = {q[62:0], 1'b0};
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        for (int i = 0; i < sh; i++) begin
            q = {q[62:0], 1'b0};
            r = {r[62:0], 1'b0};
            if (r >= den) begin
                q = q + 64'd1;
                r = r - den;
            end
        end
        if ({r[62:0], 1'b0} >= den) q = q + 64'd1;
        return neg ? -$signed(P_W'(q)) : $signed(P_W'(q));
    endfunction

    // COEF[m][n]: coefficient of V^m * A^n, scaled by 256^m * 32^n, Q30
    localparam logic signed [P_W-1:0] COEF [4][4] = '{
        '{dec_to_fixed(-773452, 5, 30), dec_to_fixed(-1799, 5, 35),
          dec_to_fixed(-427, 5, 40),    dec_to_fixed(18829, 8, 45)},
        '{dec_to_fixed(2804, 5, 38),    dec_to_fixed(772, 5, 43),
          dec_to_fixed(83744, 8, 48),   dec_to_fixed(-3387, 8, 53)},
        '{dec_to_fixed(-21988, 8, 46),  dec_to_fixed(-5219, 8, 51),
          dec_to_fixed(-744, 8, 56),    dec_to_fixed(277, 9, 61)},
        '{dec_to_fixed(108, 8, 54),     dec_to_fixed(247, 9, 59),
          dec_to_fixed(487, 10, 64),    dec_to_fixed(379, 12, 69)}
    };

    function automatic logic [P_W-1:0] mag_of(input logic signed [P_W-1:0] v);
        return v[P_W-1] ? P_W'(-v) : P_W'(v);
    endfunction

endpackage

`default_nettype wire

>>> hdl/vtmf_exp2_frac.sv
// 2^f for f in [0,1): twelve-term Taylor series of exp(z), two register stages per term.
// Depends on vtmf_pkg.
`default_nettype none

module vtmf_exp2_frac
    import vtmf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [29:0] in_z,
    input  wire vtmf_side_t  in_side,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [32:0]      out_m,
    output vtmf_side_t       out_side
);

    localparam int TERMS = 12;
    localparam int NS    = 2 * TERMS;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    logic [60:0]  ta_prod_reg [TERMS];
    logic [32:0]  ta_sum_reg  [TERMS];
    logic [29:0]  ta_z_reg    [TERMS];
    vtmf_side_t   ta_side_reg [TERMS];
    logic [66:0]  tb_prod_reg [TERMS];
    logic [32:0]  tb_sum_reg  [TERMS];
    logic [29:0]  tb_z_reg    [TERMS];
    vtmf_side_t   tb_side_reg [TERMS];

    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int s = NS - 2; s >= 0; s--) en[s] = !vld_reg[s] || en[s+1];
    end

    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (en[s]) vld_reg[s] <= (s == 0) ? in_valid : vld_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    for (genvar g = 0; g < TERMS; g++) begin : g_term
        localparam int          I    = g + 1;
        localparam logic [30:0] HALF = 31'(I / 2);
        // exact quotient by I for dividends below 2^31
        localparam logic [35:0] M    = 36'(((64'd1 << 35) + I - 1) / I);

        logic [30:0] term;
        logic [32:0] sum_in;
        logic [29:0] z_in;
        vtmf_side_t  side_in;
        logic [30:0] n_rnd;

        if (g == 0) begin : g_first
            assign term    = 31'h40000000;
            assign sum_in  = 33'h40000000;
            assign z_in    = in_z;
            assign side_in = in_side;
        end else begin : g_rest
            assign term    = tb_prod_reg[g-1][65:35];
            assign sum_in  = tb_sum_reg[g-1] + 33'(term);
            assign z_in    = tb_z_reg[g-1];
            assign side_in = tb_side_reg[g-1];
        end

        assign n_rnd = 31'((ta_prod_reg[g] + 61'h20000000) >> 30) + HALF;

        always_ff @(posedge aclk) begin
            if (en[2*g]) begin
                ta_prod_reg[g] <= 61'(term) * 61'(z_in);
                ta_sum_reg[g]  <= sum_in;
                ta_z_reg[g]    <= z_in;
                ta_side_reg[g] <= side_in;
            end
            if (en[2*g+1]) begin
                tb_prod_reg[g] <= 67'(n_rnd) * 67'(M);
                tb_sum_reg[g]  <= ta_sum_reg[g];
                tb_z_reg[g]    <= ta_z_reg[g];
                tb_side_reg[g] <= ta_side_reg[g];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_m     = tb_sum_reg[TERMS-1] + 33'(tb_prod_reg[TERMS-1][65:35]);
    assign out_side  = tb_side_reg[TERMS-1];

endmodule

`default_nettype wire

>>> hdl/vt_micro_fuel_rate_unit.sv
// Top level of the fuel-rate unit: unit conversion, polynomial, exponent split, output.
// Depends on vtmf_pkg and vtmf_exp2_frac.
`default_nettype none

// Fully pipelined: one transaction per clock while results are taken, with
// 18 stages for the unit conversion, the 4x4 Horner polynomial and the log2(e)
// scaling, 24 for the Taylor series of 2^f and one output register. Every stage
// stalls on its own, so gaps close up behind a held result and input keeps
// flowing until the pipeline is actually full. No state survives a transaction.
module vt_micro_fuel_rate_unit
    import vtmf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [13:0]        s_speed_mps,
    input  wire logic signed [11:0] s_accel_mps2,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [31:0]             m_rate_value,
    output logic                    m_saturated
);

    localparam int NF = 18;

    logic [NF-1:0] vld_reg;
    logic [NF-1:0] en;
    logic          tay_in_ready;
    logic          tay_out_valid;
    logic          en_o;
    logic [32:0]   tay_m;
    vtmf_side_t    tay_side;

    always_comb begin
        en[NF-1] = !vld_reg[NF-1] || tay_in_ready;
        for (int s = NF - 2; s >= 0; s--) en[s] = !vld_reg[s] || en[s+1];
    end

    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int s = 0; s < NF; s++) begin
                if (en[s]) vld_reg[s] <= (s == 0) ? s_valid : vld_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // Stage 0/1: V/256 and A/32 in Q20, via *57.6 and *460.8 with rounding
    logic [11:0] amag;
    logic [23:0] nx_reg, ny_reg;
    logic        yneg0_reg;
    logic [55:0] px, py;
    logic [19:0] x1_reg, ymag1_reg;
    logic        yneg1_reg;

    assign amag = s_accel_mps2[11] ? 12'(-s_accel_mps2) : 12'(s_accel_mps2);
    assign px   = 56'(nx_reg) * 56'(RECIP_10);
    assign py   = 56'(ny_reg) * 56'(RECIP_10);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            nx_reg    <= 24'(s_speed_mps) * 24'd576 + 24'd5;
            ny_reg    <= 24'(amag) * 24'd4608 + 24'd5;
            yneg0_reg <= s_accel_mps2[11];
        end
        if (en[1]) begin
            x1_reg    <= px[54:35];
            ymag1_reg <= py[54:35];
            yneg1_reg <= yneg0_reg;
        end
    end

    // Operand carry lines
    logic [19:0] x_c_reg  [2:11];
    logic [19:0] ym_c_reg [2:5];
    logic        yn_c_reg [2:5];

    for (genvar s = 2; s <= 11; s++) begin : g_xc
        always_ff @(posedge aclk) begin
            if (en[s]) x_c_reg[s] <= (s == 2) ? x1_reg : x_c_reg[(s == 2) ? 2 : s - 1];
        end
    end

    for (genvar s = 2; s <= 5; s++) begin : g_yc
        always_ff @(posedge aclk) begin
            if (en[s]) begin
                ym_c_reg[s] <= (s == 2) ? ymag1_reg : ym_c_reg[(s == 2) ? 2 : s - 1];
                yn_c_reg[s] <= (s == 2) ? yneg1_reg : yn_c_reg[(s == 2) ? 2 : s - 1];
            end
        end
    end

    // Stages 2..7: Horner in A for all four rows, product then round-and-add
    logic [63:0]            ya_prod_reg [3][4];
    logic                   ya_neg_reg  [3][4];
    logic signed [P_W-1:0]  yp_reg      [3][4];

    for (genvar j = 0; j < 3; j++) begin : g_ystep
        localparam int SA = 2 + 2 * j;
        logic [19:0] ym;
        logic        yn;
        if (j == 0) begin : g_y0
            assign ym = ymag1_reg;
            assign yn = yneg1_reg;
        end else begin : g_yn
            assign ym = ym_c_reg[SA-1];
            assign yn = yn_c_reg[SA-1];
        end
        for (genvar m = 0; m < 4; m++) begin : g_row
            logic signed [P_W-1:0] p_in;
            logic [63:0]           rnd;
            logic [P_W-1:0]        r;
            if (j == 0) begin : g_c
                assign p_in = COEF[m][3];
            end else begin : g_p
                assign p_in = yp_reg[j-1][m];
            end
            assign rnd = ya_prod_reg[j][m] + 64'h80000;
            assign r   = rnd[63:20];
            always_ff @(posedge aclk) begin
                if (en[SA]) begin
                    ya_prod_reg[j][m] <= 64'(mag_of(p_in)) * 64'(ym);
                    ya_neg_reg[j][m]  <= p_in[P_W-1] ^ yn;
                end
                if (en[SA+1]) begin
                    yp_reg[j][m] <= (ya_neg_reg[j][m] ? -$signed(r) : $signed(r))
                                    + COEF[m][2-j];
                end
            end
        end
    end

    // Rows 0..2 wait for the Horner in V
    logic signed [P_W-1:0] rc_reg [8:12][3];

    for (genvar s = 8; s <= 12; s++) begin : g_rc
        always_ff @(posedge aclk) begin
            if (en[s]) begin
                for (int m = 0; m < 3; m++)
                    rc_reg[s][m] <= (s == 8) ? yp_reg[2][m] : rc_reg[(s == 8) ? 8 : s - 1][m];
            end
        end
    end

    // Stages 8..13: Horner in V
    logic [63:0]           xa_prod_reg [3];
    logic                  xa_neg_reg  [3];
    logic signed [P_W-1:0] t_reg       [3];

    for (genvar q = 0; q < 3; q++) begin : g_xstep
        localparam int SA = 8 + 2 * q;
        logic signed [P_W-1:0] t_in;
        logic [63:0]           rnd;
        logic [P_W-1:0]        r;
        if (q == 0) begin : g_t0
            assign t_in = yp_reg[2][3];
        end else begin : g_tn
            assign t_in = t_reg[q-1];
        end
        assign rnd = xa_prod_reg[q] + 64'h80000;
        assign r   = rnd[63:20];
        always_ff @(posedge aclk) begin
            if (en[SA]) begin
                xa_prod_reg[q] <= 64'(mag_of(t_in)) * 64'(x_c_reg[SA-1]);
                xa_neg_reg[q]  <= t_in[P_W-1];
            end
            if (en[SA+1]) begin
                t_reg[q] <= (xa_neg_reg[q] ? -$signed(r) : $signed(r)) + rc_reg[SA][2-q];
            end
        end
    end

    // Stages 14..17: u = t*log2(e), split into k and f, z = f*ln2
    logic [P_W-1:0]     t_mag;
    logic [72:0]        u_prod_reg;
    logic               u_neg_reg;
    logic               hi14_reg, lo14_reg;
    logic [72:0]        u_rnd;
    logic [44:0]        u_mag;
    logic signed [45:0] u_val;
    logic [45:0]        w_val;
    logic [29:0]        f15_reg;
    vtmf_side_t         side15_reg, side16_reg, side17_reg;
    logic [59:0]        zp_reg;
    logic [59:0]        z_rnd;
    logic [29:0]        z17_reg;

    // k and f only matter for |t| < 20.0, which fits in 36 bits
    assign t_mag = mag_of(t_reg[2]);
    assign u_rnd = u_prod_reg + 73'h8000000;
    assign u_mag = u_rnd[72:28];
    assign u_val = u_neg_reg ? -$signed(46'(u_mag)) : $signed(46'(u_mag));
    assign w_val = 46'(u_val) + (46'd32 << 30);
    assign z_rnd = zp_reg + 60'h20000000;

    always_ff @(posedge aclk) begin
        if (en[14]) begin
            u_prod_reg <= 73'(t_mag[35:0]) * 73'(LOG2E_Q28);
            u_neg_reg  <= t_reg[2][P_W-1];
            hi14_reg   <= (t_reg[2] >= T_SAT_Q30);
            lo14_reg   <= (t_reg[2] < T_ZERO_Q30);
        end
        if (en[15]) begin
            f15_reg            <= w_val[29:0];
            side15_reg.k       <= w_val[35:30];
            side15_reg.sat_hi  <= hi14_reg;
            side15_reg.zero_lo <= lo14_reg;
        end
        if (en[16]) begin
            zp_reg     <= 60'(f15_reg) * 60'(LN2_Q30);
            side16_reg <= side15_reg;
        end
        if (en[17]) begin
            z17_reg    <= z_rnd[59:30];
            side17_reg <= side16_reg;
        end
    end

    vtmf_exp2_frac u_exp2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[NF-1]),
        .in_ready  (tay_in_ready),
        .in_z      (z17_reg),
        .in_side   (side17_reg),
        .out_valid (tay_out_valid),
        .out_ready (en_o),
        .out_m     (tay_m),
        .out_side  (tay_side)
    );

    // Output: scale 2^f by 2^(k-8) with rounding, then clamp
    logic        m_valid_reg;
    logic [31:0] rate_reg, rate_next;
    logic        sat_reg, sat_next;
    logic [5:0]  sh;
    logic [39:0] raw;

    assign en_o = !m_valid_reg || m_ready;
    assign sh   = 6'd38 - tay_side.k;

    always_comb begin
        if (tay_side.k == 6'd39) begin
            raw = 40'(tay_m) << 1;
        end else if (tay_side.k == 6'd38) begin
            raw = 40'(tay_m);
        end else begin
            raw = (40'(tay_m) + (40'd1 << (sh - 6'd1))) >> sh;
        end
        rate_next = raw[31:0];
        sat_next  = 1'b0;
        if (tay_side.sat_hi) begin
            rate_next = '1;
            sat_next  = 1'b1;
        end else if (tay_side.zero_lo) begin
            rate_next = '0;
        end else if (tay_side.k >= 6'd40 || raw[39:32] != 8'd0) begin
            rate_next = '1;
            sat_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_o) begin
            m_valid_reg <= tay_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_o) begin
            rate_reg <= rate_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_rate_value = rate_reg;
    assign m_saturated  = sat_reg;

endmodule

`default_nettype wire

>>> hdl/vtmf_checker.sv
// Port-level checks for vt_micro_fuel_rate_unit, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module vtmf_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [31:0]        m_rate_value,
    input wire logic               m_saturated
);

    // a held result keeps its transaction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rate_value) && $stable(m_saturated))
        else $error("result changed while stalled");

    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_rate_value == 32'hFFFFFFFF)
        else $error("saturation flag without full-scale rate");

    // an empty output register means no stage can be blocked
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with output free");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind vt_micro_fuel_rate_unit vtmf_checker u_vtmf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_rate_value (m_rate_value),
    .m_saturated  (m_saturated)
);

`default_nettype wire

>>> verif/vtmf_rate_checker.sv
// Checker for the fuel-rate unit: watches both channels, predicts each rate and compares.
// Self-contained; sits beside the block in tb_top and reports a failure count.
module vtmf_rate_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [13:0] s_speed_mps,
    input  logic [11:0] s_accel_mps2,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_rate_value,
    input  logic        m_saturated,
    output int          fail_count,
    output int          rates_pending
);

    typedef struct packed {
        logic [31:0] rate;
        logic        sat;
    } fuel_rate_t;

    localparam int N_FRAC = 30;
    localparam longint unsigned L2E_Q28 = 64'd387270501;
    localparam longint unsigned LN2Q30 = 64'd744261118;
    localparam int EXP_DEPTH = 1024;

    // coefficient = num * 10^-dexp, rows are powers of speed, columns of accel
    localparam int POLY_NUM [4][4] = '{
        '{-773452, -1799, -427, 18829},
        '{2804, 772, 83744, -3387},
        '{-21988, -5219, -744, 277},
        '{108, 247, 487, 379}
    };
    localparam int POLY_DEXP [4][4] = '{
        '{5, 5, 5, 8}, '{5, 5, 8, 8}, '{8, 8, 8, 9}, '{8, 9, 10, 12}
    };

    // expected results in order, as a ring indexed by running counts
    fuel_rate_t rate_ring [EXP_DEPTH];
    int         wr_cnt;
    int         rd_cnt;

    function automatic longint scaled_coef(input int mi, input int ni);
        longint unsigned den, mag, q, r;
        int sh;
        den = 1;
        for (int i = 0; i < POLY_DEXP[mi][ni]; i++) den = den * 10;
        mag = POLY_NUM[mi][ni] < 0 ? longint'(-POLY_NUM[mi][ni]) : longint'(POLY_NUM[mi][ni]);
        q = mag / den;
        r = mag % den;
        sh = 8 * mi + 5 * ni + N_FRAC;
        for (int i = 0; i < sh; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin
                q++;
                r = r - den;
            end
        end
        if (2 * r >= den) q++;
        return POLY_NUM[mi][ni] < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint prod_rnd(input longint a, input longint b, input int sh);
        longint unsigned ua, ub, p;
        logic neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = ua * ub;
        p = (p + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned exp2_frac(input longint unsigned f);
        longint unsigned z, term, acc;
        z = (f * LN2Q30 + (64'd1 << (N_FRAC - 1))) >> N_FRAC;
        term = 64'd1 << N_FRAC;
        acc = term;
        for (longint unsigned i = 1; i <= 12; i++) begin
            term = (term * z + (64'd1 << (N_FRAC - 1))) >> N_FRAC;
            term = (term + i / 2) / i;
            acc += term;
        end
        return acc;
    endfunction

    function automatic fuel_rate_t fuel_rate(input logic [13:0] spd, input logic [11:0] acc);
        fuel_rate_t res;
        longint x, y, t, u, row [4];
        longint unsigned amag, w, k, mant, raw;
        int sh;
        res = '0;
        x = (longint'(spd) * 576 + 5) / 10;
        amag = acc[11] ? 4096 - acc : acc;
        y = longint'((amag * 4608 + 5) / 10);
        if (acc[11]) y = -y;
        for (int mi = 0; mi < 4; mi++) begin
            row[mi] = scaled_coef(mi, 3);
            for (int ni = 2; ni >= 0; ni--)
                row[mi] = prod_rnd(row[mi], y, 20) + scaled_coef(mi, ni);
        end
        t = row[3];
        for (int mi = 2; mi >= 0; mi--) t = prod_rnd(t, x, 20) + row[mi];
        if (t >= (longint'(6) << N_FRAC)) begin
            res.rate = '1;
            res.sat = 1'b1;
            return res;
        end
        if (t < -(longint'(20) << N_FRAC)) return res;
        u = prod_rnd(t, L2E_Q28, 28);
        w = u + (longint'(32) << N_FRAC);
        k = w >> N_FRAC;
        mant = exp2_frac(w & ((64'd1 << N_FRAC) - 1));
        if (k >= 40) raw = 64'h1_0000_0000;
        else if (k == 39) raw = mant << 1;
        else if (k == 38) raw = mant;
        else begin
            sh = 38 - int'(k);
            raw = (mant + (64'd1 << (sh - 1))) >> sh;
        end
        if (raw > 64'hFFFF_FFFF) begin
            res.rate = '1;
            res.sat = 1'b1;
        end else begin
            res.rate = raw[31:0];
        end
        return res;
    endfunction

    initial begin
        fail_count = 0;
        wr_cnt = 0;
        rd_cnt = 0;
    end
    assign rates_pending = wr_cnt - rd_cnt;

    always @(posedge aclk) begin
        fuel_rate_t exp_rate;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                rate_ring[wr_cnt[9:0]] = fuel_rate(s_speed_mps, s_accel_mps2);
                wr_cnt++;
            end
            if (m_valid && m_ready) begin
                if (wr_cnt == rd_cnt) begin
                    $display("%0t: unexpected transaction rate=%h sat=%b", $time,
                             m_rate_value, m_saturated);
                    fail_count++;
                end else begin
                    exp_rate = rate_ring[rd_cnt[9:0]];
                    rd_cnt++;
                    if (exp_rate.rate !== m_rate_value || exp_rate.sat !== m_saturated) begin
                        $display("%0t: mismatch expected rate=%h sat=%b actual rate=%h sat=%b",
                                 $time, exp_rate.rate, exp_rate.sat, m_rate_value, m_saturated);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for vt_micro_fuel_rate_unit: clock, reset, stimulus and verdict.
// Depends on the RTL and vtmf_rate_checker, which does the prediction and comparison.
module tb_top;

    localparam int CYCLE_LIMIT = 300000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [13:0] s_speed_mps;
    logic [11:0] s_accel_mps2;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_rate_value;
    logic        m_saturated;
    int          fail_count;
    int          rates_pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycles;

    vt_micro_fuel_rate_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_speed_mps(s_speed_mps), .s_accel_mps2(s_accel_mps2),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_rate_value(m_rate_value), .m_saturated(m_saturated)
    );

    vtmf_rate_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_speed_mps(s_speed_mps), .s_accel_mps2(s_accel_mps2),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_rate_value(m_rate_value), .m_saturated(m_saturated),
        .fail_count(fail_count), .rates_pending(rates_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // one transaction; valid is only dropped for sender idle cycles
    task automatic send_sample(input logic [13:0] spd, input logic [11:0] acc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_speed_mps = spd;
        s_accel_mps2 = acc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: send_sample(14'($urandom_range(3000)), 12'($urandom));
                1: send_sample(14'($urandom), 12'($urandom_range(255) - 128));
                default: send_sample(14'($urandom), 12'($urandom));
            endcase
        end
    endtask

    task automatic drain;
        s_valid = 1'b0;
        while (rates_pending != 0) @(negedge aclk);
    endtask

    initial begin
        logic [13:0] spd_edge [4];
        logic [11:0] acc_edge [5];
        spd_edge = '{14'd0, 14'd1, 14'd5000, 14'h3FFF};
        acc_edge = '{12'h800, 12'h7FF, 12'h000, 12'hFFF, 12'h100};
        s_valid = 1'b0;
        s_speed_mps = '0;
        s_accel_mps2 = '0;
        send_idle_pct = 18;
        recv_idle_pct = 88;
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // field extremes: includes the saturating and the very low sums
        foreach (spd_edge[i])
            foreach (acc_edge[j]) send_sample(spd_edge[i], acc_edge[j]);
        send_sample(14'h2AAA, 12'h555);
        send_sample(14'h1555, 12'hAAA);
        send_random(230);
        drain;

        send_idle_pct = 88;
        recv_idle_pct = 18;
        send_random(230);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(230);
        drain;
        repeat (60) @(posedge aclk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
